// ----- src/life_pkg.sv -----
`default_nettype none
package life_pkg;

  // grid geometry
  localparam int GRID_ROWS = 16;
  localparam int GRID_COLS = 16;
  localparam int ROW_W     = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;

  // port widths fixed by the request format
  localparam int IDX_W  = 4;
  localparam int BITS_W = 16;

  // B3/S23 rule
  localparam int NBR_COUNT     = 8;
  localparam int BIRTH_COUNT   = 3;
  localparam int SURVIVE_COUNT = 2;
  localparam int CNT_W         = $clog2(NBR_COUNT + 1);

  // request actions
  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_STEP = 1'b1;

  typedef logic [GRID_COLS-1:0] row_t;
  typedef logic [ROW_W-1:0]     row_addr_t;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

endpackage
`default_nettype wire

// ----- src/life_lane.sv -----
`default_nettype none
module life_lane (
  input  wire logic                                   self_alive,
  input  wire logic [life_pkg::NBR_COUNT-1:0]         nbr,
  output logic                                        next_alive
);
  import life_pkg::*;

  logic [CNT_W-1:0] count;

  // count live neighbors
  always_comb begin
    count = '0;
    for (int i = 0; i < NBR_COUNT; i++) begin
      count = count + CNT_W'(nbr[i]);
    end
  end

  // apply birth and survival rule
  assign next_alive = (count == CNT_W'(BIRTH_COUNT)) ||
                      (self_alive && (count == CNT_W'(SURVIVE_COUNT)));

endmodule
`default_nettype wire

// ----- src/life_row_unit.sv -----
`default_nettype none
module life_row_unit (
  input  wire life_pkg::row_t above,
  input  wire life_pkg::row_t mid,
  input  wire life_pkg::row_t below,
  output life_pkg::row_t      new_row
);
  import life_pkg::*;

  // pad with dead cells beyond the left and right edges
  logic [GRID_COLS+1:0] above_p;
  logic [GRID_COLS+1:0] mid_p;
  logic [GRID_COLS+1:0] below_p;

  assign above_p = {1'b0, above, 1'b0};
  assign mid_p   = {1'b0, mid,   1'b0};
  assign below_p = {1'b0, below, 1'b0};

  // one lane per column; lane outputs merge into the new row word
  for (genvar c = 0; c < GRID_COLS; c++) begin : g_lane
    logic [NBR_COUNT-1:0] nbr;
    assign nbr = {above_p[c+2], above_p[c+1], above_p[c],
                  mid_p[c+2],                 mid_p[c],
                  below_p[c+2], below_p[c+1], below_p[c]};

    life_lane u_lane (
      .self_alive (mid[c]),
      .nbr        (nbr),
      .next_alive (new_row[c])
    );
  end

endmodule
`default_nettype wire

// ----- src/life_automaton_step.sv -----
// Load request: busy stays low, and one load is taken per cycle while idle.
// Step request: busy while the sweep runs, one row computed per cycle from a
// three-row window; row r is registered onto the out_ ports for one cycle.
// No new request is taken until busy drops after a step.
// The receiver cannot stall; out_valid pulses once per row with no gaps.
// Synchronous active-low reset clears the grid to all dead and returns to idle.
`default_nettype none
module life_automaton_step (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic                          in_action,
  input  wire logic [life_pkg::IDX_W-1:0]    in_row_index,
  input  wire logic [life_pkg::BITS_W-1:0]   in_row_bits,
  output logic                               out_valid,
  output logic [life_pkg::IDX_W-1:0]         out_row_index,
  output logic [life_pkg::BITS_W-1:0]        out_row_bits,
  output logic                               out_last_row
);
  import life_pkg::*;

  state_t    state_r, state_nxt;
  row_addr_t row_r, row_nxt;
  row_t      prev_r, prev_nxt;
  row_t      cur_r, cur_nxt;
  row_t      grid_r [GRID_ROWS];

  logic      accept;
  logic      load_hit;
  logic      at_last;
  row_addr_t ld_addr;
  row_addr_t rd_addr;
  row_t      below;
  row_t      new_row;

  assign busy     = (state_r == ST_RUN);
  assign accept   = start && !busy;
  assign ld_addr  = ROW_W'(in_row_index);
  assign load_hit = accept && (in_action == ACT_LOAD) &&
                    (32'(in_row_index) < GRID_ROWS);
  assign at_last  = (row_r == ROW_W'(GRID_ROWS - 1));
  assign rd_addr  = ROW_W'(row_r + 1'b1);

  // fetch the old row below the current one; dead past the bottom edge
  always_comb begin
    if (at_last) begin
      below = '0;
    end else begin
      below = grid_r[rd_addr];
    end
  end

  life_row_unit u_row (
    .above   (prev_r),
    .mid     (cur_r),
    .below   (below),
    .new_row (new_row)
  );

  // sequence the row sweep
  always_comb begin
    state_nxt = state_r;
    row_nxt   = row_r;
    prev_nxt  = prev_r;
    cur_nxt   = cur_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && (in_action == ACT_STEP)) begin
          state_nxt = ST_RUN;
          row_nxt   = '0;
          prev_nxt  = '0;
          cur_nxt   = grid_r[0];
        end
      end
      ST_RUN: begin
        prev_nxt = cur_r;
        cur_nxt  = below;
        row_nxt  = rd_addr;
        if (at_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      row_r   <= '0;
    end else begin
      state_r <= state_nxt;
      row_r   <= row_nxt;
    end
  end

  // hold the window rows
  always_ff @(posedge clk) begin
    prev_r <= prev_nxt;
    cur_r  <= cur_nxt;
  end

  // write loads, and write back each new row once its old value sits in the window
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < GRID_ROWS; i++) begin
        grid_r[i] <= '0;
      end
    end else if (busy) begin
      grid_r[row_r] <= new_row;
    end else if (load_hit) begin
      grid_r[ld_addr] <= GRID_COLS'(in_row_bits);
    end
  end

  // register results
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= busy;
    end
  end

  always_ff @(posedge clk) begin
    out_row_index <= IDX_W'(row_r);
    out_row_bits  <= BITS_W'(new_row);
    out_last_row  <= at_last;
  end

  // checks
  a_valid_from_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == ST_RUN))
    else $error("result strobe without a running sweep");

  a_rows_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last_row) |=> out_valid)
    else $error("gap in row results before last row");

  a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last_row) |-> (out_row_index == IDX_W'(GRID_ROWS - 1)))
    else $error("last row flag on wrong row");

  a_step_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_action == ACT_STEP)) |=> busy)
    else $error("step request did not start a sweep");

endmodule
`default_nettype wire
